[sv/sturmian_line_point_generator_macros.svh]
// Assertion macros shared by the sturmian line point generator.
`ifndef STURMIAN_LINE_POINT_GENERATOR_MACROS_SVH
`define STURMIAN_LINE_POINT_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define SLPG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slpg: same-cycle check failed");

// Next-cycle implication, checked on every rising clk edge outside reset.
`define SLPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slpg: next-cycle check failed");

`endif

[sv/slpg_pkg.sv]
// Types, constants and microcode table of the sturmian line point generator.
package slpg_pkg;

  localparam int unsigned IN_W      = 7;
  localparam int unsigned OCT_W     = 3;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned CENTER_W  = 10;
  localparam int unsigned ERR_W     = 14;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned PC_W      = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_DIV,
    OP_FIX,
    OP_PT
  } op_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_WAIT_IN,
    BR_EMPTY,
    BR_DIV,
    BR_PT,
    BR_JUMP
  } br_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t op;
    br_t br;
    pc_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic empty;
    logic div_more;
    logic pt_stay;
    logic pt_load;
  } status_t;

  localparam pc_t PC_WAIT  = 3'd0;
  localparam pc_t PC_CHECK = 3'd1;
  localparam pc_t PC_DIV   = 3'd2;
  localparam pc_t PC_FIX   = 3'd3;
  localparam pc_t PC_PT    = 3'd4;
  localparam pc_t PC_DONE  = 3'd5;

  // The control program. Unused addresses fall back to the wait step.
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    unique case (pc)
      PC_WAIT:  w = '{op: OP_LOAD, br: BR_WAIT_IN, target: PC_WAIT};
      PC_CHECK: w = '{op: OP_MUL,  br: BR_EMPTY,   target: PC_WAIT};
      PC_DIV:   w = '{op: OP_DIV,  br: BR_DIV,     target: PC_DIV};
      PC_FIX:   w = '{op: OP_FIX,  br: BR_NEXT,    target: PC_WAIT};
      PC_PT:    w = '{op: OP_PT,   br: BR_PT,      target: PC_PT};
      PC_DONE:  w = '{op: OP_NOP,  br: BR_JUMP,    target: PC_WAIT};
      default:  w = '{op: OP_NOP,  br: BR_JUMP,    target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

[sv/slpg_sequencer.sv]
// Step counter and branch logic that walks the microcode table.
module slpg_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  slpg_pkg::status_t status,
  output slpg_pkg::ctrl_t   ctrl
);
  import slpg_pkg::*;

  pc_t pc_r;
  pc_t pc_nxt;
  pc_t pc_inc;

  assign ctrl   = ucode(pc_r);
  assign pc_inc = PC_W'(pc_r + 1'b1);

  always_comb begin
    unique case (ctrl.br)
      BR_NEXT:    pc_nxt = pc_inc;
      BR_WAIT_IN: pc_nxt = status.in_fire ? pc_inc : pc_r;
      BR_EMPTY:   pc_nxt = status.empty ? ctrl.target : pc_inc;
      BR_DIV:     pc_nxt = status.div_more ? ctrl.target : pc_inc;
      BR_PT:      pc_nxt = status.pt_stay ? ctrl.target : pc_inc;
      BR_JUMP:    pc_nxt = ctrl.target;
      default:    pc_nxt = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[sv/slpg_datapath.sv]
// Operand registers, remainder unit, line stepper and output register.
module slpg_datapath #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  slpg_pkg::op_t                          op,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [slpg_pkg::OCT_W-1:0]             in_octant,
  input  logic [slpg_pkg::IN_W-1:0]              in_length,
  input  logic [slpg_pkg::IN_W-1:0]              in_slope_num,
  input  logic [slpg_pkg::IN_W-1:0]              in_slope_den,
  input  logic [slpg_pkg::IN_W-1:0]              in_tie_index,
  input  logic                                   cfg_we,
  input  logic [slpg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [slpg_pkg::CENTER_W-1:0]          cfg_wdata,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [slpg_pkg::COORD_W-1:0]    out_column,
  output logic signed [slpg_pkg::COORD_W-1:0]    out_row,
  output logic                                   out_last,
  output slpg_pkg::status_t                      status
);
  import slpg_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam logic [IN_W-1:0] MAX_LEN_IN = IN_W'(MAX_LEN);

  logic [OCT_W-1:0]    oct_r;
  logic [LEN_W-1:0]    n_r;
  logic [IN_W-1:0]     p_r;
  logic [IN_W-1:0]     q_r;
  logic [IN_W-1:0]     a_r;
  logic [ERR_W-1:0]    div_r;
  logic [IN_W-1:0]     rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [ERR_W-1:0]    err_r;
  logic [LEN_W-1:0]    minor_r;
  logic [LEN_W-1:0]    s_r;
  logic [CENTER_W-1:0] center_x_r;
  logic [CENTER_W-1:0] center_y_r;
  logic [COORD_W-1:0]  col_r;
  logic [COORD_W-1:0]  row_r;
  logic                last_r;
  logic                out_valid_r;

  logic                in_fire;
  logic [LEN_W-1:0]    n_load;
  logic [IN_W:0]       trial;
  logic [IN_W:0]       den_ext;
  logic [IN_W-1:0]     rem_nxt;
  logic [ERR_W-1:0]    err_fix;
  logic [LEN_W-1:0]    s_nxt;
  logic [ERR_W-1:0]    err_add;
  logic                early;
  logic                hit;
  logic [ERR_W-1:0]    err_nxt;
  logic [LEN_W-1:0]    minor_nxt;
  logic [COORD_W-1:0]  x_mag;
  logic [COORD_W-1:0]  y_mag;
  logic [COORD_W-1:0]  x_neg;
  logic [COORD_W-1:0]  y_neg;
  logic [COORD_W-1:0]  col_nxt;
  logic [COORD_W-1:0]  row_nxt;
  logic                last_nxt;
  logic                pt_load;

  assign in_ready = rst_n && (op == OP_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign n_load   = (in_length > MAX_LEN_IN) ? LEN_W'(MAX_LEN) : in_length[LEN_W-1:0];

  // One restoring step of the remainder: shift in the next product bit.
  assign den_ext = {1'b0, q_r};
  assign trial   = {rem_r, div_r[ERR_W-1]};
  assign rem_nxt = (trial >= den_ext) ? IN_W'(trial - den_ext) : trial[IN_W-1:0];
  assign err_fix = (rem_r == '0) ? '0 : ERR_W'(q_r - rem_r);

  // Line step: the tie rule switches from >= to > once the step passes a.
  assign s_nxt     = LEN_W'(s_r + 1'b1);
  assign err_add   = err_r + ERR_W'(p_r);
  assign early     = (IN_W'(s_nxt) <= a_r);
  assign hit       = early ? (err_add >= ERR_W'(q_r)) : (err_add > ERR_W'(q_r));
  assign err_nxt   = hit ? ERR_W'(err_add - ERR_W'(q_r)) : err_add;
  assign minor_nxt = LEN_W'(minor_r + LEN_W'(hit));
  assign last_nxt  = (s_nxt == n_r);

  assign x_mag = COORD_W'(s_nxt);
  assign y_mag = COORD_W'(minor_nxt);
  assign x_neg = oct_r[0] ? COORD_W'(12'd0 - x_mag) : x_mag;
  assign y_neg = oct_r[1] ? COORD_W'(12'd0 - y_mag) : y_mag;
  assign col_nxt = COORD_W'((oct_r[2] ? y_neg : x_neg) + COORD_W'(center_x_r));
  assign row_nxt = COORD_W'((oct_r[2] ? x_neg : y_neg) + COORD_W'(center_y_r));

  assign pt_load = (op == OP_PT) && (!out_valid_r || out_ready);

  assign status.in_fire  = in_fire;
  assign status.empty    = (q_r == '0) || (n_r == '0);
  assign status.div_more = (cnt_r != '0);
  assign status.pt_stay  = !(pt_load && last_nxt);
  assign status.pt_load  = pt_load;

  assign out_valid  = out_valid_r;
  assign out_column = signed'(col_r);
  assign out_row    = signed'(row_r);
  assign out_last   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CENTER_X: center_x_r <= cfg_wdata;
          REG_CENTER_Y: center_y_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (pt_load) begin
        out_valid_r <= 1'b1;
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        last_r      <= last_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (op)
        OP_LOAD: begin
          if (in_fire) begin
            oct_r <= in_octant;
            n_r   <= n_load;
            p_r   <= in_slope_num;
            q_r   <= in_slope_den;
            a_r   <= in_tie_index;
          end
        end
        OP_MUL: begin
          div_r <= ERR_W'(ERR_W'(a_r) * ERR_W'(p_r));
          rem_r <= '0;
          cnt_r <= CNT_W'(ERR_W - 1);
        end
        OP_DIV: begin
          rem_r <= rem_nxt;
          div_r <= {div_r[ERR_W-2:0], 1'b0};
          cnt_r <= CNT_W'(cnt_r - 1'b1);
        end
        OP_FIX: begin
          err_r   <= err_fix;
          s_r     <= '0;
          minor_r <= '0;
        end
        OP_PT: begin
          if (pt_load) begin
            err_r   <= err_nxt;
            s_r     <= s_nxt;
            minor_r <= minor_nxt;
          end
        end
        OP_NOP: ;
        default: ;
      endcase
    end
  end

endmodule

[sv/sturmian_line_point_generator.sv]
// Top level of the sturmian line point generator: sequencer, datapath and checks.
//
// Each input item is a line request (octant, length n, slope p/q, tie index a);
// the block answers with the n points of the digital straight segment of slope
// p/q, one output item per point, the final one flagged by out_last. Work is
// run by a small microcoded sequencer: after the item is taken, one step forms
// the product a*p, fourteen steps of a bit-serial restoring divider produce
// (a*p) mod q, one step turns that into the start error, and then a single step
// repeats once per point, handing one point per cycle to the output register
// while the consumer keeps up. An item with n or q equal to zero yields nothing.
// Otherwise the next item is taken only once every point of the previous one
// has entered the output register, and output backpressure, which stalls the
// point step, delays it. Lengths beyond MAX_LEN are cut to MAX_LEN points.
// The last point may still wait in the output register while the next item is
// accepted. center_x and center_y are written through cfg_we, cfg_index and
// cfg_wdata and should change only while no line is in progress.
module sturmian_line_point_generator #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [slpg_pkg::OCT_W-1:0]          in_octant,
  input  logic [slpg_pkg::IN_W-1:0]           in_length,
  input  logic [slpg_pkg::IN_W-1:0]           in_slope_num,
  input  logic [slpg_pkg::IN_W-1:0]           in_slope_den,
  input  logic [slpg_pkg::IN_W-1:0]           in_tie_index,
  input  logic                                cfg_we,
  input  logic [slpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slpg_pkg::CENTER_W-1:0]       cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [slpg_pkg::COORD_W-1:0] out_column,
  output logic signed [slpg_pkg::COORD_W-1:0] out_row,
  output logic                                out_last
);
  import slpg_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  slpg_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  slpg_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (ctrl.op),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_octant    (in_octant),
    .in_length    (in_length),
    .in_slope_num (in_slope_num),
    .in_slope_den (in_slope_den),
    .in_tie_index (in_tie_index),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_column   (out_column),
    .out_row      (out_row),
    .out_last     (out_last),
    .status       (status)
  );

`include "sturmian_line_point_generator_macros.svh"

  // An accepted item always moves on to the product and empty check.
  `SLPG_ASSERT_NEXT(a_accept_to_check, in_valid && in_ready, ctrl.op == OP_MUL)
  // A non-empty request always enters the remainder loop.
  `SLPG_ASSERT_NEXT(a_check_to_div, (ctrl.op == OP_MUL) && !status.empty, ctrl.op == OP_DIV)
  // A new point never overwrites one the consumer has not taken.
  `SLPG_ASSERT_IMPL(a_no_overwrite, out_valid && !out_ready, !status.pt_load)

endmodule
